// ===== design/bitmap_block_allocator_macros.svh =====
// Assertion macros for the bitmap block allocator.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BBA_ASSERT(lbl, prop, msg)

`define BBA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/bba_pkg.sv =====
package bba_pkg;

  localparam int unsigned CntW  = 12;
  localparam int unsigned IdxW  = 11;
  localparam int unsigned WordW = 32;
  localparam int unsigned BitW  = 5;

  typedef enum logic [1:0] {
    ModeAlloc = 2'd0,
    ModeFree  = 2'd1,
    ModeCheck = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StFull     = 3'd1,
    StRange    = 3'd2,
    StFree     = 3'd3,
    StBad      = 3'd4
  } status_e;

  function automatic logic [5:0] popcount32(input logic [WordW-1:0] w);
    logic [1:0] s1 [16];
    logic [2:0] s2 [8];
    logic [3:0] s3 [4];
    logic [4:0] s4 [2];
    for (int i = 0; i < 16; i++) s1[i] = {1'b0, w[2*i]} + {1'b0, w[2*i+1]};
    for (int i = 0; i < 8; i++) s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
    for (int i = 0; i < 4; i++) s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
    for (int i = 0; i < 2; i++) s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
    return {1'b0, s4[0]} + {1'b0, s4[1]};
  endfunction

  function automatic logic [BitW-1:0] first_zero32(input logic [WordW-1:0] w);
    logic [BitW-1:0] pos;
    pos = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (!w[i]) begin
        pos = BitW'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== design/bitmap_block_allocator.sv =====
// First-fit bitmap block allocator. Each item on the input stream (tuser = mode,
// tdata = block index) gives exactly one result item (tuser = status, tdata = result
// index, used count, free count). The used bits live in a memory of 32-bit words, and
// allocate and check walk it one word per cycle through one shared read port, so an
// allocate stops at the first word that holds a free block and a check reads all
// ceil(block_count / 32) words; an allocate that finds no free block reads as many
// words as a check, and a free reads the block's word and clears the bit if it is set.
// The block takes one item at a time and holds tready low while it works. After reset
// and after every write of block_count the map is cleared by a pass over all
// ceil(MAX_BLOCKS / 32) words, 64 by default, during which no item is taken.
`include "bitmap_block_allocator_macros.svh"

module bitmap_block_allocator #(
  parameter int unsigned MAX_BLOCKS = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,      // block_count
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // block_index [10:0], zero fill
  input  logic [1:0]  s_axis_tuser_i,   // mode [1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // result_index [10:0], used_blocks [22:11],
                                        // free_blocks [34:23], zero fill
  output logic [2:0]  m_axis_tuser_o    // status [2:0]
);

  localparam int unsigned Words = (MAX_BLOCKS + 31) / 32;
  localparam int unsigned AW    = (Words > 1) ? $clog2(Words) : 1;
  localparam logic [15:0] MaxB16 = 16'(MAX_BLOCKS);
  localparam logic [11:0] NReset = (MAX_BLOCKS > 2048) ? 12'd2048 : 12'(MAX_BLOCKS);

  typedef enum logic [2:0] {
    SClear,
    SIdle,
    SScan,
    SFreeRd,
    SFreeChk,
    SDone
  } state_e;

  state_e                         state_q;
  logic [AW-1:0]                  iss_ptr_q;
  logic                           iss_live_q;
  logic                           rvalid_q;
  logic [AW-1:0]                  raddr_q;
  logic [bba_pkg::WordW-1:0]      rdata_q;
  logic [bba_pkg::CntW-1:0]       n_q;
  logic [bba_pkg::CntW-1:0]       used_q;
  logic [bba_pkg::CntW-1:0]       free_q;
  logic [bba_pkg::CntW-1:0]       cnt_q;
  logic [1:0]                     mode_q;
  logic [bba_pkg::IdxW-1:0]       bidx_q;
  bba_pkg::status_e               status_q;
  logic [bba_pkg::IdxW-1:0]       ridx_q;
  logic                           m_valid_q;
  logic [39:0]                    m_data_q;
  logic [2:0]                     m_user_q;

  logic [bba_pkg::WordW-1:0]      map_mem [Words];

  logic                           mem_re;
  logic                           mem_we;
  logic [AW-1:0]                  mem_raddr;
  logic [AW-1:0]                  mem_waddr;
  logic [bba_pkg::WordW-1:0]      mem_wdata;

  logic [bba_pkg::CntW-1:0]       nm1;
  logic [bba_pkg::CntW-1:0]       last12;
  logic                           iss_last;
  logic                           scan_last;
  logic [bba_pkg::WordW-1:0]      tail_used;
  logic [bba_pkg::WordW-1:0]      alloc_word;
  logic                           found;
  logic [bba_pkg::BitW-1:0]       bitpos;
  logic [5:0]                     pop;
  logic [bba_pkg::CntW-1:0]       cnt_sum;
  logic [AW-1:0]                  free_addr;
  logic                           free_bit;
  logic [bba_pkg::CntW-1:0]       cfg_eff;
  logic [bba_pkg::IdxW-1:0]       in_idx;
  logic                           in_accept;
  logic                           out_load;

  assign nm1       = n_q - 12'd1;
  assign last12    = {5'b0, nm1[11:5]};
  assign iss_last  = (12'(iss_ptr_q) == last12);
  assign scan_last = (12'(raddr_q) == last12);
  assign tail_used = ~(32'hFFFF_FFFF >> (5'd31 - nm1[4:0]));
  assign alloc_word = rdata_q | (scan_last ? tail_used : '0);
  assign found     = ~&alloc_word;
  assign bitpos    = bba_pkg::first_zero32(alloc_word);
  assign pop       = bba_pkg::popcount32(rdata_q);
  assign cnt_sum   = cnt_q + 12'(pop);
  assign free_addr = AW'(bidx_q[10:5]);
  assign free_bit  = rdata_q[bidx_q[4:0]];
  assign cfg_eff   = ({4'b0, cfg_wdata_i} > MaxB16) ? MaxB16[11:0] : cfg_wdata_i;
  assign in_idx    = s_axis_tdata_i[10:0];

  assign s_axis_tready_o = (state_q == SIdle) && !cfg_we_i;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == SDone) && !cfg_we_i && (!m_valid_q || m_axis_tready_i);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  always_comb begin
    mem_re    = ((state_q == SScan) && iss_live_q) || (state_q == SFreeRd);
    mem_raddr = (state_q == SFreeRd) ? free_addr : iss_ptr_q;
    mem_we    = 1'b0;
    mem_waddr = iss_ptr_q;
    mem_wdata = '0;
    case (state_q)
      SClear: begin
        mem_we = 1'b1;
      end
      SScan: begin
        mem_we    = rvalid_q && (mode_q == bba_pkg::ModeAlloc) && found;
        mem_waddr = raddr_q;
        mem_wdata = rdata_q | (32'b1 << bitpos);
      end
      SFreeChk: begin
        mem_we    = free_bit;
        mem_waddr = free_addr;
        mem_wdata = rdata_q & ~(32'b1 << bidx_q[4:0]);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= map_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SClear;
      iss_ptr_q  <= '0;
      iss_live_q <= 1'b0;
      rvalid_q   <= 1'b0;
      n_q        <= NReset;
      used_q     <= '0;
      free_q     <= NReset;
      m_valid_q  <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        n_q        <= cfg_eff;
        used_q     <= '0;
        free_q     <= cfg_eff;
        iss_ptr_q  <= '0;
        iss_live_q <= 1'b0;
        rvalid_q   <= 1'b0;
        state_q    <= SClear;
      end else begin
        case (state_q)
          SClear: begin
            if (iss_ptr_q == AW'(Words - 1)) begin
              state_q <= SIdle;
            end else begin
              iss_ptr_q <= iss_ptr_q + 1'b1;
            end
          end
          SIdle: begin
            if (in_accept) begin
              mode_q     <= s_axis_tuser_i;
              bidx_q     <= in_idx;
              ridx_q     <= '0;
              status_q   <= bba_pkg::StOk;
              cnt_q      <= '0;
              iss_ptr_q  <= '0;
              iss_live_q <= 1'b0;
              rvalid_q   <= 1'b0;
              state_q    <= SDone;
              case (s_axis_tuser_i)
                bba_pkg::ModeAlloc: begin
                  if (n_q == '0) begin
                    status_q <= bba_pkg::StFull;
                  end else begin
                    iss_live_q <= 1'b1;
                    state_q    <= SScan;
                  end
                end
                bba_pkg::ModeFree: begin
                  if ({1'b0, in_idx} >= n_q) begin
                    status_q <= bba_pkg::StRange;
                  end else begin
                    state_q <= SFreeRd;
                  end
                end
                bba_pkg::ModeCheck: begin
                  if (({1'b0, used_q} + {1'b0, free_q}) != {1'b0, n_q}) begin
                    status_q <= bba_pkg::StBad;
                  end else if (n_q == '0) begin
                    if (used_q != '0) begin
                      status_q <= bba_pkg::StBad;
                    end
                  end else begin
                    iss_live_q <= 1'b1;
                    state_q    <= SScan;
                  end
                end
                default: begin
                  state_q <= SDone;
                end
              endcase
            end
          end
          SScan: begin
            rvalid_q <= iss_live_q;
            raddr_q  <= iss_ptr_q;
            if (iss_live_q) begin
              if (iss_last) begin
                iss_live_q <= 1'b0;
              end else begin
                iss_ptr_q <= iss_ptr_q + 1'b1;
              end
            end
            if (rvalid_q) begin
              if (mode_q == bba_pkg::ModeAlloc) begin
                if (found) begin
                  used_q     <= used_q + 12'd1;
                  free_q     <= free_q - 12'd1;
                  ridx_q     <= bba_pkg::IdxW'({12'(raddr_q), bitpos});
                  iss_live_q <= 1'b0;
                  rvalid_q   <= 1'b0;
                  state_q    <= SDone;
                end else if (scan_last) begin
                  status_q   <= bba_pkg::StFull;
                  iss_live_q <= 1'b0;
                  rvalid_q   <= 1'b0;
                  state_q    <= SDone;
                end
              end else begin
                cnt_q <= cnt_sum;
                if (scan_last) begin
                  if (cnt_sum != used_q) begin
                    status_q <= bba_pkg::StBad;
                  end
                  iss_live_q <= 1'b0;
                  rvalid_q   <= 1'b0;
                  state_q    <= SDone;
                end
              end
            end
          end
          SFreeRd: begin
            state_q <= SFreeChk;
          end
          SFreeChk: begin
            if (free_bit) begin
              used_q <= used_q - 12'd1;
              free_q <= free_q + 12'd1;
            end else begin
              status_q <= bba_pkg::StFree;
            end
            state_q <= SDone;
          end
          SDone: begin
            if (out_load) begin
              m_user_q  <= status_q;
              m_data_q  <= {5'b0, free_q, used_q, ridx_q};
              state_q   <= SIdle;
            end
          end
          default: begin
            state_q <= SIdle;
          end
        endcase
      end
    end
  end

  `BBA_ASSERT(a_counts_sum, (used_q + free_q) == n_q, "used plus free differs from block count")
  `BBA_ASSERT(a_used_bound, used_q <= n_q, "used count exceeds block count")
  `BBA_ASSERT_NEXT(a_busy_after_accept, in_accept, !s_axis_tready_o, "ready right after an item")

endmodule
